// File: design/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in every cycle where the antecedent holds.
`define FFBTA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The expression must never be true.
`define FFBTA_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("assertion failed");

`endif

// File: design/ffbta_pkg.sv
`default_nettype none

package ffbta_pkg;

  localparam int unsigned POOL_UNITS_DEF   = 1024;
  localparam int unsigned HEADER_UNITS_DEF = 1;

  localparam int unsigned REQ_W    = 10;
  localparam int unsigned OFF_W    = 10;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_CHK,
    S_A_SPLIT,
    S_FOL_CHK,
    S_F_CHK,
    S_F_NCHK,
    S_F_HW,
    S_F_PREV,
    S_F_PCHK,
    S_F_ZH
  } state_e;

  // Port controls of the header store.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

`default_nettype wire

// File: design/ffbta_ram.sv
`default_nettype none

module ffbta_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/ffbta_ctrl.sv
`default_nettype none

module ffbta_ctrl #(
  parameter int unsigned POOL_UNITS   = ffbta_pkg::POOL_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = ffbta_pkg::HEADER_UNITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic                                   op_i,
  input  wire logic [ffbta_pkg::REQ_W-1:0]            req_size_i,
  input  wire logic [ffbta_pkg::OFF_W-1:0]            block_offset_i,
  output logic                                        done_o,
  output logic [ffbta_pkg::STATUS_W-1:0]              status_o,
  output logic [ffbta_pkg::OFF_W-1:0]                 payload_offset_o,
  output ffbta_pkg::mem_ctl_t                         mem_ctl_o,
  output logic [$clog2(POOL_UNITS)-1:0]               mem_waddr_o,
  output logic [2*$clog2(POOL_UNITS+1):0]             mem_wdata_o,
  output logic [$clog2(POOL_UNITS)-1:0]               mem_raddr_o,
  input  wire logic [2*$clog2(POOL_UNITS+1):0]        mem_rdata_i
);

  localparam int unsigned AW = $clog2(POOL_UNITS);
  localparam int unsigned LW = $clog2(POOL_UNITS + 1);
  localparam int unsigned EW = 2 * LW + 1;
  // Working width: holds twice the pool size and any request plus header.
  localparam int unsigned CW = ((LW > 11) ? LW : 11) + 1;
  localparam logic [CW-1:0] POOL_C = CW'(POOL_UNITS);
  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_UNITS);
  localparam logic [AW-1:0] CLR_LAST = AW'(POOL_UNITS - 1);

  function automatic logic [EW-1:0] pack_hdr(input logic occ, input logic [CW-1:0] len,
                                             input logic [CW-1:0] prev);
    return {occ, len[LW-1:0], prev[LW-1:0]};
  endfunction

  ffbta_pkg::state_e  state_q, state_d;
  ffbta_pkg::state_e  ret_q, ret_d;
  ffbta_pkg::status_e status_q, status_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [CW-1:0]      pos_q, pos_d;
  logic [CW-1:0]      tot_q, tot_d;
  logic [CW-1:0]      hlen_q, hlen_d;
  logic [CW-1:0]      hprev_q, hprev_d;
  logic [CW-1:0]      fol_q, fol_d;
  logic [CW-1:0]      fol_len_q, fol_len_d;
  logic               done_q, done_d;
  logic [ffbta_pkg::OFF_W-1:0] pay_q, pay_d;

  // Fields of the header just read.
  logic          rd_occ;
  logic [CW-1:0] rd_len;
  logic [CW-1:0] rd_prev;

  logic          accept;
  logic [CW-1:0] off_ext;
  logic          off_bad;
  logic [CW-1:0] a_rest;
  logic          a_fit;
  logic          a_split;
  logic [CW-1:0] a_next;
  logic [CW-1:0] a_pay;
  logic [CW-1:0] a_nb;
  logic [CW-1:0] a_nn;
  logic          f_ok;
  logic [CW-1:0] f_nxt;
  logic          mfree;
  logic [CW-1:0] hmerged;
  logic [CW-1:0] n_fol;
  logic          f_has_prev;
  logic [CW-1:0] p_addr;
  logic [CW-1:0] plen;
  logic [CW-1:0] p_fol;

  assign rd_occ  = mem_rdata_i[EW-1];
  assign rd_len  = CW'(mem_rdata_i[2*LW-1:LW]);
  assign rd_prev = CW'(mem_rdata_i[LW-1:0]);

  assign busy    = (state_q != ffbta_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign off_ext = CW'(block_offset_i);
  assign off_bad = (off_ext < HDR_C) || (off_ext >= POOL_C);

  assign a_rest  = rd_len - tot_q;
  assign a_fit   = !rd_occ && (rd_len >= tot_q);
  assign a_split = (a_rest >= HDR_C);
  assign a_next  = pos_q + rd_len;
  assign a_pay   = pos_q + HDR_C;
  assign a_nb    = pos_q + tot_q;
  assign a_nn    = fol_q + fol_len_q;

  assign f_ok       = (rd_len != '0) && rd_occ;
  assign f_nxt      = pos_q + rd_len;
  assign mfree      = (rd_len != '0) && !rd_occ;
  assign hmerged    = hlen_q + rd_len;
  assign n_fol      = pos_q + hmerged;
  assign f_has_prev = (pos_q != '0) && (hprev_q <= pos_q);
  assign p_addr     = pos_q - hprev_q;
  assign plen       = rd_len + hlen_q;
  assign p_fol      = p_addr + fol_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffbta_pkg::S_CLR;
      ret_q   <= ffbta_pkg::S_IDLE;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    pay_q     <= pay_d;
    pos_q     <= pos_d;
    tot_q     <= tot_d;
    hlen_q    <= hlen_d;
    hprev_q   <= hprev_d;
    fol_q     <= fol_d;
    fol_len_q <= fol_len_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffbta_pkg::S_CLR: begin
        if (clr_q == CLR_LAST) begin
          state_d = ffbta_pkg::S_IDLE;
        end
      end
      ffbta_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == ffbta_pkg::OP_ALLOC) begin
            state_d = ffbta_pkg::S_A_CHK;
          end else if (!off_bad) begin
            state_d = ffbta_pkg::S_F_CHK;
          end
        end
      end
      ffbta_pkg::S_A_CHK: begin
        if (rd_len == '0) begin
          state_d = ffbta_pkg::S_IDLE;
        end else if (a_fit) begin
          state_d = a_split ? ffbta_pkg::S_A_SPLIT : ffbta_pkg::S_IDLE;
        end else if (a_next >= POOL_C) begin
          state_d = ffbta_pkg::S_IDLE;
        end
      end
      ffbta_pkg::S_A_SPLIT: begin
        state_d = (a_nn < POOL_C) ? ffbta_pkg::S_FOL_CHK : ffbta_pkg::S_IDLE;
      end
      ffbta_pkg::S_FOL_CHK: begin
        state_d = ret_q;
      end
      ffbta_pkg::S_F_CHK: begin
        if (!f_ok) begin
          state_d = ffbta_pkg::S_IDLE;
        end else if (f_nxt < POOL_C) begin
          state_d = ffbta_pkg::S_F_NCHK;
        end else begin
          state_d = ffbta_pkg::S_F_PREV;
        end
      end
      ffbta_pkg::S_F_NCHK: begin
        if (!mfree) begin
          state_d = ffbta_pkg::S_F_PREV;
        end else if (n_fol < POOL_C) begin
          state_d = ffbta_pkg::S_FOL_CHK;
        end else begin
          state_d = ffbta_pkg::S_F_HW;
        end
      end
      ffbta_pkg::S_F_HW: begin
        state_d = ffbta_pkg::S_F_PREV;
      end
      ffbta_pkg::S_F_PREV: begin
        state_d = f_has_prev ? ffbta_pkg::S_F_PCHK : ffbta_pkg::S_IDLE;
      end
      ffbta_pkg::S_F_PCHK: begin
        state_d = mfree ? ffbta_pkg::S_F_ZH : ffbta_pkg::S_IDLE;
      end
      ffbta_pkg::S_F_ZH: begin
        state_d = (p_fol < POOL_C) ? ffbta_pkg::S_FOL_CHK : ffbta_pkg::S_IDLE;
      end
      default: begin
        state_d = ffbta_pkg::S_IDLE;
      end
    endcase
  end

  // Memory accesses, datapath registers and the result.
  always_comb begin
    mem_ctl_o   = '0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;
    ret_d       = ret_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    tot_d       = tot_q;
    hlen_d      = hlen_q;
    hprev_d     = hprev_q;
    fol_d       = fol_q;
    fol_len_d   = fol_len_q;
    done_d      = 1'b0;
    status_d    = status_q;
    pay_d       = pay_q;
    case (state_q)
      ffbta_pkg::S_CLR: begin
        // Sweep the whole store; entry zero becomes one free block over the pool.
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = clr_q;
        mem_wdata_o  = (clr_q == '0) ? pack_hdr(1'b0, POOL_C, '0) : '0;
        clr_d        = clr_q + 1'b1;
      end
      ffbta_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == ffbta_pkg::OP_ALLOC) begin
            tot_d        = CW'(req_size_i) + HDR_C;
            pos_d        = '0;
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = '0;
          end else begin
            pay_d = '0;
            if (off_bad) begin
              done_d   = 1'b1;
              status_d = ffbta_pkg::ST_BAD_ADDR;
            end else begin
              pos_d        = off_ext - HDR_C;
              mem_ctl_o.re = 1'b1;
              mem_raddr_o  = off_ext[AW-1:0] - HDR_C[AW-1:0];
            end
          end
        end
      end
      ffbta_pkg::S_A_CHK: begin
        if (rd_len == '0) begin
          done_d   = 1'b1;
          status_d = ffbta_pkg::ST_NO_SPACE;
          pay_d    = '0;
        end else if (a_fit) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = pos_q[AW-1:0];
          mem_wdata_o  = pack_hdr(1'b1, a_split ? tot_q : rd_len, rd_prev);
          status_d     = ffbta_pkg::ST_DONE;
          pay_d        = a_pay[ffbta_pkg::OFF_W-1:0];
          if (a_split) begin
            fol_d     = a_nb;
            fol_len_d = a_rest;
          end else begin
            done_d = 1'b1;
          end
        end else if (a_next >= POOL_C) begin
          done_d   = 1'b1;
          status_d = ffbta_pkg::ST_NO_SPACE;
          pay_d    = '0;
        end else begin
          // Go on to the next block header.
          pos_d        = a_next;
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = a_next[AW-1:0];
        end
      end
      ffbta_pkg::S_A_SPLIT: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = fol_q[AW-1:0];
        mem_wdata_o  = pack_hdr(1'b0, fol_len_q, tot_q);
        if (a_nn < POOL_C) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = a_nn[AW-1:0];
          fol_d        = a_nn;
          ret_d        = ffbta_pkg::S_IDLE;
        end else begin
          done_d = 1'b1;
        end
      end
      ffbta_pkg::S_FOL_CHK: begin
        // Refresh the previous-length field of the block that follows, if one starts there.
        if (rd_len != '0) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = fol_q[AW-1:0];
          mem_wdata_o  = pack_hdr(rd_occ, rd_len, fol_len_q);
        end
        if (ret_q == ffbta_pkg::S_IDLE) begin
          done_d   = 1'b1;
          status_d = ffbta_pkg::ST_DONE;
        end
      end
      ffbta_pkg::S_F_CHK: begin
        status_d = ffbta_pkg::ST_DONE;
        if (!f_ok) begin
          done_d = 1'b1;
        end else begin
          hlen_d       = rd_len;
          hprev_d      = rd_prev;
          fol_d        = f_nxt;
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = pos_q[AW-1:0];
          mem_wdata_o  = pack_hdr(1'b0, rd_len, rd_prev);
          if (f_nxt < POOL_C) begin
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = f_nxt[AW-1:0];
          end
        end
      end
      ffbta_pkg::S_F_NCHK: begin
        if (mfree) begin
          hlen_d       = hmerged;
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = fol_q[AW-1:0];
          mem_wdata_o  = '0;
          if (n_fol < POOL_C) begin
            mem_ctl_o.re = 1'b1;
            mem_raddr_o  = n_fol[AW-1:0];
            fol_d        = n_fol;
            fol_len_d    = hmerged;
            ret_d        = ffbta_pkg::S_F_HW;
          end
        end
      end
      ffbta_pkg::S_F_HW: begin
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = pos_q[AW-1:0];
        mem_wdata_o  = pack_hdr(1'b0, hlen_q, hprev_q);
      end
      ffbta_pkg::S_F_PREV: begin
        if (f_has_prev) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = p_addr[AW-1:0];
        end else begin
          done_d = 1'b1;
        end
      end
      ffbta_pkg::S_F_PCHK: begin
        if (mfree) begin
          mem_ctl_o.we = 1'b1;
          mem_waddr_o  = p_addr[AW-1:0];
          mem_wdata_o  = pack_hdr(1'b0, plen, rd_prev);
          fol_len_d    = plen;
        end else begin
          done_d = 1'b1;
        end
      end
      ffbta_pkg::S_F_ZH: begin
        // The freed header is absorbed into the block before it.
        mem_ctl_o.we = 1'b1;
        mem_waddr_o  = pos_q[AW-1:0];
        mem_wdata_o  = '0;
        if (p_fol < POOL_C) begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = p_fol[AW-1:0];
          fol_d        = p_fol;
          ret_d        = ffbta_pkg::S_IDLE;
        end else begin
          done_d = 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign payload_offset_o = pay_q;

endmodule

`default_nettype wire

// File: design/first_fit_boundary_tag_allocator_top.sv
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       op_i, req_size_i, block_offset_i
// result    out        done_o, one cycle, no stall status_o, payload_offset_o
//
// After reset the header store is swept once, one entry a cycle, with busy high
// until the sweep ends. An allocate walks one block header per cycle through the
// store's read port; a split gives the remainder a header and refreshes the
// previous-length field of the block after it. A free does read-modify-write
// steps on itself and its two neighbors; an offset outside the pool is refused.
// The result strobe comes with busy low; it cannot be stalled.

`default_nettype none
`include "assert_macros.svh"

module first_fit_boundary_tag_allocator_top #(
  parameter int unsigned POOL_UNITS   = ffbta_pkg::POOL_UNITS_DEF,
  parameter int unsigned HEADER_UNITS = ffbta_pkg::HEADER_UNITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          op_i,
  input  wire logic [ffbta_pkg::REQ_W-1:0]   req_size_i,
  input  wire logic [ffbta_pkg::OFF_W-1:0]   block_offset_i,
  output logic                               done_o,
  output logic [ffbta_pkg::STATUS_W-1:0]     status_o,
  output logic [ffbta_pkg::OFF_W-1:0]        payload_offset_o
);

  localparam int unsigned AW = $clog2(POOL_UNITS);
  localparam int unsigned LW = $clog2(POOL_UNITS + 1);
  localparam int unsigned EW = 2 * LW + 1;

  ffbta_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_wdata;
  logic [EW-1:0]       mem_rdata;
  logic                rw_clash;
  logic                denied_offset;

  ffbta_ctrl #(
    .POOL_UNITS   (POOL_UNITS),
    .HEADER_UNITS (HEADER_UNITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .req_size_i       (req_size_i),
    .block_offset_i   (block_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o),
    .mem_ctl_o        (mem_ctl),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  ffbta_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_UNITS)
  ) u_hdr_store (
    .clk_i   (clk_i),
    .we_i    (mem_ctl.we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_ctl.re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rw_clash      = mem_ctl.we && mem_ctl.re && (mem_waddr == mem_raddr);
  assign denied_offset = done_o && (status_o != ffbta_pkg::ST_DONE) && (payload_offset_o != '0);

  // A header is never read in the same cycle that it is rewritten.
  `FFBTA_ASSERT_NEVER(a_rw_same_entry, clk_i, rst_ni, rw_clash)
  // A result is presented only once the block is idle again.
  `FFBTA_ASSERT_NEVER(a_done_when_idle, clk_i, rst_ni, done_o && busy)
  // A result whose status is not done carries a zero offset.
  `FFBTA_ASSERT_NEVER(a_offset_only_grant, clk_i, rst_ni, denied_offset)
  // While idle the store is only read.
  `FFBTA_ASSERT_IMPLY(a_no_write_idle, clk_i, rst_ni, !busy, !mem_ctl.we)

endmodule

`default_nettype wire

// File: verif/first_fit_boundary_tag_allocator_top_test.sv
`timescale 1ns / 100ps

module first_fit_boundary_tag_allocator_top_test;

  localparam int unsigned POOL        = ffbta_pkg::POOL_UNITS_DEF;
  localparam int unsigned HDR         = ffbta_pkg::HEADER_UNITS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 64;

  // One header entry: occupied bit, block length, length of the block before it.
  typedef struct packed {
    bit        used;
    bit [10:0] size;
    bit [10:0] prev_size;
  } tag_t;

  typedef struct packed {
    ffbta_pkg::status_e          status;
    logic [ffbta_pkg::OFF_W-1:0] payload;
  } grant_t;

  logic                           clk_i          = 1'b0;
  logic                           rst_ni         = 1'b0;
  logic                           start          = 1'b0;
  logic                           busy;
  logic                           op_i           = ffbta_pkg::OP_ALLOC;
  logic [ffbta_pkg::REQ_W-1:0]    req_size_i     = '0;
  logic [ffbta_pkg::OFF_W-1:0]    block_offset_i = '0;
  logic                           done_o;
  logic [ffbta_pkg::STATUS_W-1:0] status_o;
  logic [ffbta_pkg::OFF_W-1:0]    payload_offset_o;

  tag_t        tag_mem [POOL];
  bit          is_head [POOL];
  grant_t      pending_grants [$];
  grant_t      due_grant;
  int unsigned live_offsets [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;

  first_fit_boundary_tag_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .req_size_i       (req_size_i),
    .block_offset_i   (block_offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .payload_offset_o (payload_offset_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_pool();
    for (int i = 0; i < POOL; i++) begin
      tag_mem[i] = '0;
      is_head[i] = 1'b0;
    end
    is_head[0]      = 1'b1;
    tag_mem[0].size = 11'(POOL);
  endfunction

  function automatic void fix_follower(int unsigned pos, int unsigned len);
    int unsigned nxt;
    nxt = pos + len;
    if (nxt < POOL && is_head[nxt]) tag_mem[nxt].prev_size = 11'(len);
  endfunction

  function automatic grant_t carve_block(int unsigned req);
    int unsigned need, at, len, rest;
    grant_t      g;
    need      = req + HDR;
    at        = 0;
    g.status  = ffbta_pkg::ST_NO_SPACE;
    g.payload = '0;
    while (at < POOL) begin
      len = tag_mem[at].size;
      if (len == 0) break;
      if (!tag_mem[at].used && len >= need) begin
        rest = len - need;
        tag_mem[at].used = 1'b1;
        // The remainder becomes a free block of its own when a header fits.
        if (rest >= HDR) begin
          tag_mem[at].size             = 11'(need);
          is_head[at + need]           = 1'b1;
          tag_mem[at + need].used      = 1'b0;
          tag_mem[at + need].size      = 11'(rest);
          tag_mem[at + need].prev_size = 11'(need);
          fix_follower(at + need, rest);
        end
        g.status  = ffbta_pkg::ST_DONE;
        g.payload = ffbta_pkg::OFF_W'(at + HDR);
        return g;
      end
      at += len;
    end
    return g;
  endfunction

  function automatic grant_t release_block(int unsigned off);
    int unsigned h, nxt, p;
    grant_t      g;
    g.status  = ffbta_pkg::ST_DONE;
    g.payload = '0;
    if (off < HDR || off >= POOL) begin
      g.status = ffbta_pkg::ST_BAD_ADDR;
      return g;
    end
    h = off - HDR;
    if (!is_head[h] || !tag_mem[h].used) return g;
    tag_mem[h].used = 1'b0;
    nxt = h + tag_mem[h].size;
    if (nxt < POOL && is_head[nxt] && !tag_mem[nxt].used) begin
      tag_mem[h].size        = tag_mem[h].size + tag_mem[nxt].size;
      is_head[nxt]           = 1'b0;
      tag_mem[nxt].size      = '0;
      tag_mem[nxt].prev_size = '0;
      fix_follower(h, tag_mem[h].size);
    end
    if (h != 0 && tag_mem[h].prev_size <= h) begin
      p = h - tag_mem[h].prev_size;
      if (is_head[p] && !tag_mem[p].used) begin
        tag_mem[p].size      = tag_mem[p].size + tag_mem[h].size;
        is_head[h]           = 1'b0;
        tag_mem[h].size      = '0;
        tag_mem[h].prev_size = '0;
        fix_follower(p, tag_mem[p].size);
      end
    end
    return g;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Drives one command, waits until it is accepted, records the expected grant
  // and then either keeps start high for the burst or idles for a while.
  task automatic send_cmd(ffbta_pkg::op_e op, int unsigned req, int unsigned off,
                          output grant_t g);
    start          <= 1'b1;
    op_i           <= op;
    req_size_i     <= ffbta_pkg::REQ_W'(req);
    block_offset_i <= ffbta_pkg::OFF_W'(off);
    do @(posedge clk_i); while (busy !== 1'b0);
    g = (op == ffbta_pkg::OP_ALLOC) ? carve_block(req) : release_block(off);
    pending_grants.push_back(g);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  // Whole-pool grants, refusal when full, bad and non-block frees, double free.
  task automatic test_whole_pool();
    grant_t g;
    send_cmd(ffbta_pkg::OP_ALLOC, 1023, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 0, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 0, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 1022, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 5, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 2, g);
  endtask

  // Splits that leave a header-sized tail, a grant whose offset wraps to zero,
  // and merges with the next block.
  task automatic test_split_tail();
    grant_t g;
    send_cmd(ffbta_pkg::OP_ALLOC, 100, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 921, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 0, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 102, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 1021, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 0, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1023, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
  endtask

  // A block freed between two free neighbors folds into one.
  task automatic test_merge_both_sides();
    grant_t g;
    send_cmd(ffbta_pkg::OP_ALLOC, 10, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 10, 0, g);
    send_cmd(ffbta_pkg::OP_ALLOC, 10, 0, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 1, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 23, g);
    send_cmd(ffbta_pkg::OP_FREE, 0, 12, g);
  endtask

  // Mostly alloc/free of live blocks with random sizes, plus stray frees.
  task automatic test_random_traffic(int unsigned n_items);
    grant_t      g;
    int unsigned pick, sz, idx;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (live_offsets.size() == 0 || (pick < 55 && live_offsets.size() < 48)) begin
        sz = $urandom_range(0, 99);
        if (sz < 70)      sz = $urandom_range(0, 31);
        else if (sz < 92) sz = $urandom_range(0, 255);
        else              sz = $urandom_range(0, 1023);
        send_cmd(ffbta_pkg::OP_ALLOC, sz, $urandom_range(0, 1023), g);
        if (g.status == ffbta_pkg::ST_DONE && g.payload >= HDR)
          live_offsets.push_back(g.payload);
      end else if (pick < 90) begin
        idx = $urandom_range(0, live_offsets.size() - 1);
        send_cmd(ffbta_pkg::OP_FREE, $urandom_range(0, 1023), live_offsets[idx], g);
        live_offsets.delete(idx);
      end else begin
        send_cmd(ffbta_pkg::OP_FREE, $urandom_range(0, 1023), $urandom_range(0, 1023), g);
      end
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_grants.size() == 0) begin
        flag_mismatch("result strobe with no command outstanding");
      end else begin
        due_grant = pending_grants.pop_front();
        if (status_o !== due_grant.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, due_grant.status));
        if (payload_offset_o !== due_grant.payload)
          flag_mismatch($sformatf("payload offset %0d, expected %0d",
                                  payload_offset_o, due_grant.payload));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    clear_pool();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_whole_pool();
    test_split_tail();
    drain();
    test_merge_both_sides();
    test_random_traffic(900);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/ffbta_pkg.sv
design/ffbta_ram.sv
design/ffbta_ctrl.sv
design/first_fit_boundary_tag_allocator_top.sv
verif/first_fit_boundary_tag_allocator_top_test.sv
